FILE: rtl/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

  localparam int CFG_W = 11;
  localparam int IDX_W = 10;
  localparam int CRN_W = 20;
  localparam int TEX_W = 17;
  localparam int POS_W = 16;

  localparam int MAX_SLICES = 1024;
  localparam int MAX_STACKS = 1024;

  localparam int DIV_STEPS     = 32;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  localparam int CORDIC_STEPS  = 18;
  localparam int CORDIC_PER    = 2;
  localparam int CORDIC_STAGES = CORDIC_STEPS / CORDIC_PER;

  // divider, cordic with output mapping, multiply, round
  localparam int LAT = DIV_STAGES + CORDIC_STAGES + 1 + 2;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] OP_GRID   = 2'd0;
  localparam logic [1:0] OP_POLE   = 2'd1;
  localparam logic [1:0] OP_CAP    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_VTX = 2'd0;
  localparam logic [1:0] KIND_TRI = 2'd1;
  localparam logic [1:0] KIND_REJ = 2'd2;

  localparam logic [1:0] CLS_REJ  = 2'd0;
  localparam logic [1:0] CLS_GRID = 2'd1;
  localparam logic [1:0] CLS_POLE = 2'd2;
  localparam logic [1:0] CLS_CAP  = 2'd3;

  localparam logic [0:0] REG_SLICES = 1'd0;
  localparam logic [0:0] REG_STACKS = 1'd1;

  typedef struct packed {
    logic             v;
    logic [1:0]       cls;
    logic             jone;
    logic [CRN_W-1:0] t0a;
    logic [CRN_W-1:0] t0b;
    logic [CRN_W-1:0] t0c;
    logic [CRN_W-1:0] t1a;
    logic [CRN_W-1:0] t1b;
    logic [CRN_W-1:0] t1c;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
  } meta_t;

  typedef struct packed {
    meta_t                   m;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } rec_t;

  function automatic logic signed [32:0] atan_turn(input int k);
    logic signed [32:0] a;
    case (k)
      0:       a = 33'sd536870912;
      1:       a = 33'sd316933405;
      2:       a = 33'sd167458907;
      3:       a = 33'sd85004756;
      4:       a = 33'sd42667331;
      5:       a = 33'sd21354465;
      6:       a = 33'sd10679838;
      7:       a = 33'sd5340245;
      8:       a = 33'sd2670163;
      9:       a = 33'sd1335087;
      10:      a = 33'sd667544;
      11:      a = 33'sd333772;
      12:      a = 33'sd166886;
      13:      a = 33'sd83443;
      14:      a = 33'sd41721;
      15:      a = 33'sd20860;
      16:      a = 33'sd10430;
      17:      a = 33'sd5215;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [63:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 64'sd32767) r = 16'sh7fff;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

  // round half up at bit k, then saturate
  function automatic logic signed [POS_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                       input int k);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (k - 1))) >>> k;
    return sat16(t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/uv_sphere_tessellator.sv
`default_nettype none
// channel  ports            tdata                        tuser  tlast
// input    in_t*            slice_index, ring_index      op     -
// result   out_t*           positions, tangents, tex,    kind   last
//                           corners
// config   cfg_*            index 0 slices, 1 stacks     -      -
//
// one transaction accepted per cycle while the result side keeps up; a grid item gives up to
// three results, one per cycle, so the result channel sets the sustained rate
// pipeline: input register, 8 divider stages, 9 cordic stages, quadrant fold,
// multiply, round, output register
// reset: synchronous, clears valid bits and sets 16 slices, 8 stacks
// a stall on the result side freezes the whole pipeline once its last stage holds an item; nothing is dropped
module uv_sphere_tessellator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // slice_index, ring_index, zero pad
  input  wire logic [23:0]  in_tdata,
  // op
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, tangent_x, tangent_z, tex_u, tex_v,
  // corner_a, corner_b, corner_c, zero pad
  output logic [175:0]      out_tdata,
  // kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [10:0]  cfg_data
);
  import uvs_pkg::*;

  logic [CFG_W-1:0] slice_r, stack_r, cfg_clamp;

  always_comb begin
    if (cfg_data < 11'd3) cfg_clamp = 11'd3;
    else if (cfg_data > 11'(MAX_SLICES)) cfg_clamp = 11'(MAX_SLICES);
    else cfg_clamp = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= 11'd16;
      stack_r <= 11'd8;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SLICES: slice_r <= cfg_clamp;
        REG_STACKS: begin
          if (cfg_data < 11'd2) stack_r <= 11'd2;
          else if (cfg_data > 11'(MAX_STACKS)) stack_r <= 11'(MAX_STACKS);
          else stack_r <= cfg_data;
        end
        default: stack_r <= stack_r;
      endcase
    end
  end

  logic adv, take;

  // input register
  logic             v1_r;
  logic [1:0]       op1_r;
  logic [IDX_W-1:0] i1_r, j1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r <= in_tuser;
      i1_r  <= in_tdata[9:0];
      j1_r  <= in_tdata[19:10];
    end
  end

  // classification and mesh indices
  meta_t            m0;
  logic             i_ok;
  logic [9:0]       nj;
  logic [10:0]      prev;
  logic [20:0]      pn, cn, topv;

  assign i_ok = ({1'b0, i1_r} < slice_r);
  assign nj   = 10'(stack_r - 11'd1);
  assign prev = (i1_r == '0) ? 11'(slice_r - 11'd1) : 11'({1'b0, i1_r} - 11'd1);
  assign pn   = 21'(prev) * 21'(nj);
  assign cn   = 21'(i1_r) * 21'(nj);
  assign topv = 21'(slice_r) * 21'(nj);

  always_comb begin
    m0 = '0;
    m0.v = v1_r;
    m0.jone = (j1_r == 10'd1);
    if (op1_r == OP_POLE) m0.cls = CLS_POLE;
    else if (op1_r == OP_CAP && i_ok) m0.cls = CLS_CAP;
    else if (op1_r == OP_GRID && i_ok && j1_r != '0 && {1'b0, j1_r} < stack_r)
      m0.cls = CLS_GRID;
    else m0.cls = CLS_REJ;
    if (op1_r == OP_CAP) begin
      m0.t0a = topv[19:0];
      m0.t0b = pn[19:0];
      m0.t0c = cn[19:0];
      m0.t1a = 20'(cn + 21'(nj) - 21'd1);
      m0.t1b = 20'(pn + 21'(nj) - 21'd1);
      m0.t1c = 20'(topv + 21'd1);
    end else begin
      m0.t0a = 20'(pn + 21'(j1_r) - 21'd2);
      m0.t0b = 20'(pn + 21'(j1_r) - 21'd1);
      m0.t0c = 20'(cn + 21'(j1_r) - 21'd2);
      m0.t1a = 20'(pn + 21'(j1_r) - 21'd1);
      m0.t1b = 20'(cn + 21'(j1_r) - 21'd1);
      m0.t1c = 20'(cn + 21'(j1_r) - 21'd2);
    end
  end

  // angle phases: i*2^32/S and j*2^32/(2T)
  logic [31:0] qa, qb;

  uvs_div u_div_a (
    .clk (clk),
    .en  (adv),
    .num (i1_r),
    .den ({1'b0, slice_r}),
    .q   (qa)
  );

  uvs_div u_div_b (
    .clk (clk),
    .en  (adv),
    .num (j1_r),
    .den ({stack_r, 1'b0}),
    .q   (qb)
  );

  logic [17:0] tu_sum, tv_sum;
  assign tu_sum = 18'(qa[31:15]) + 18'd1;
  assign tv_sum = 18'(qb[30:14]) + 18'd1;

  logic signed [31:0] ca, sa, cb, sb;

  uvs_cordic u_cordic_a (
    .clk   (clk),
    .en    (adv),
    .phase (qa),
    .cos_o (ca),
    .sin_o (sa)
  );

  uvs_cordic u_cordic_b (
    .clk   (clk),
    .en    (adv),
    .phase (qb),
    .cos_o (cb),
    .sin_o (sb)
  );

  // side information travels beside the datapath
  meta_t m_r [LAT];
  meta_t m_tex;

  // texture coordinates join once the quotients are out
  always_comb begin
    m_tex = m_r[DIV_STAGES-1];
    m_tex.tu = tu_sum[17:1];
    m_tex.tv = 17'(17'd65536 - tv_sum[17:1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) m_r[k].v <= 1'b0;
    end else if (adv) begin
      m_r[0] <= m0;
      for (int k = 1; k < LAT; k++) m_r[k] <= (k == DIV_STAGES) ? m_tex : m_r[k-1];
    end
  end

  // multiply then round
  logic signed [63:0] pxp_r, pzp_r;
  logic signed [31:0] cbd_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxp_r <= 64'(sb) * 64'(sa);
      pzp_r <= 64'(sb) * 64'(ca);
      cbd_r <= cb;
      px_r  <= rnd_sat(pxp_r, 45);
      pz_r  <= rnd_sat(pzp_r, 45);
      py_r  <= rnd_sat(64'(cbd_r), 15);
    end
  end

  rec_t rec;
  assign rec.m  = m_r[LAT-1];
  assign rec.px = px_r;
  assign rec.py = py_r;
  assign rec.pz = pz_r;

  assign adv       = !m_r[LAT-1].v || take;
  assign in_tready = adv;

  uvs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (m_r[LAT-1].v),
    .rec        (rec),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

FILE: rtl/uvs_div.sv
`default_nettype none
module uvs_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [9:0]  num,
  input  wire logic [11:0] den,
  output logic [31:0]      q
);
  import uvs_pkg::*;

  logic [12:0] r_r [DIV_STAGES];
  logic [31:0] q_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [12:0] r_in;
    logic [31:0] q_in;
    logic [12:0] r_w;
    logic [31:0] q_w;

    if (s == 0) begin : g_first
      assign r_in = {3'b0, num};
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_r[s-1];
      assign q_in = q_r[s-1];
    end

    // restoring division, one quotient bit per step
    always_comb begin
      logic [13:0] r2;
      r_w = r_in;
      q_w = q_in;
      for (int k = 0; k < DIV_PER_STAGE; k++) begin
        r2 = {r_w, 1'b0};
        if (r2 >= {2'b0, den}) begin
          r_w = 13'(r2 - {2'b0, den});
          q_w = {q_w[30:0], 1'b1};
        end else begin
          r_w = r2[12:0];
          q_w = {q_w[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s] <= r_w;
        q_r[s] <= q_w;
      end
    end
  end

  assign q = q_r[DIV_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/uvs_cordic.sv
`default_nettype none
module uvs_cordic (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] phase,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import uvs_pkg::*;

  logic signed [33:0] x_r  [CORDIC_STAGES];
  logic signed [33:0] y_r  [CORDIC_STAGES];
  logic signed [32:0] z_r  [CORDIC_STAGES];
  logic        [1:0]  qd_r [CORDIC_STAGES];
  logic signed [31:0] c_r, s_r;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_st
    logic signed [33:0] x_in, y_in, x_w, y_w;
    logic signed [32:0] z_in, z_w;
    logic        [1:0]  qd_in;

    if (s == 0) begin : g_first
      assign x_in  = CORDIC_GAIN;
      assign y_in  = '0;
      assign z_in  = {3'b0, phase[29:0]};
      assign qd_in = phase[31:30];
    end else begin : g_next
      assign x_in  = x_r[s-1];
      assign y_in  = y_r[s-1];
      assign z_in  = z_r[s-1];
      assign qd_in = qd_r[s-1];
    end

    always_comb begin
      logic signed [33:0] dx, dy;
      x_w = x_in;
      y_w = y_in;
      z_w = z_in;
      for (int t = 0; t < CORDIC_PER; t++) begin
        dx = y_w >>> (s * CORDIC_PER + t);
        dy = x_w >>> (s * CORDIC_PER + t);
        if (!z_w[32]) begin
          x_w = x_w - dx;
          y_w = y_w + dy;
          z_w = z_w - atan_turn(s * CORDIC_PER + t);
        end else begin
          x_w = x_w + dx;
          y_w = y_w - dy;
          z_w = z_w + atan_turn(s * CORDIC_PER + t);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]  <= x_w;
        y_r[s]  <= y_w;
        z_r[s]  <= z_w;
        qd_r[s] <= qd_in;
      end
    end
  end

  // quadrant fold-out
  always_ff @(posedge clk) begin
    if (en) begin
      case (qd_r[CORDIC_STAGES-1])
        2'd0: begin
          c_r <= 32'(x_r[CORDIC_STAGES-1]);
          s_r <= 32'(y_r[CORDIC_STAGES-1]);
        end
        2'd1: begin
          c_r <= 32'(-y_r[CORDIC_STAGES-1]);
          s_r <= 32'(x_r[CORDIC_STAGES-1]);
        end
        2'd2: begin
          c_r <= 32'(-x_r[CORDIC_STAGES-1]);
          s_r <= 32'(-y_r[CORDIC_STAGES-1]);
        end
        default: begin
          c_r <= 32'(y_r[CORDIC_STAGES-1]);
          s_r <= 32'(-x_r[CORDIC_STAGES-1]);
        end
      endcase
    end
  end

  assign cos_o = c_r;
  assign sin_o = s_r;

endmodule
`default_nettype wire

FILE: rtl/uvs_seq.sv
`default_nettype none
module uvs_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rec_valid,
  input  wire uvs_pkg::rec_t rec,
  output logic               take,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // pos_x, pos_y, pos_z, tangent_x, tangent_z, tex_u, tex_v,
  // corner_a, corner_b, corner_c, zero pad
  output logic [175:0]       out_tdata,
  // kind
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import uvs_pkg::*;

  rec_t       rec_r;
  logic       sv_r;
  logic [1:0] idx_r;
  logic [1:0] cnt;
  logic       last_now;

  logic [1:0]              kind;
  logic signed [POS_W-1:0] px, py, pz, tx, tz;
  logic [TEX_W-1:0]        tu, tv;
  logic [CRN_W-1:0]        ca, cb, cc;

  always_comb begin
    case (rec_r.m.cls)
      CLS_GRID: cnt = rec_r.m.jone ? 2'd1 : 2'd3;
      CLS_POLE: cnt = 2'd2;
      CLS_CAP:  cnt = 2'd2;
      default:  cnt = 2'd1;
    endcase
  end

  assign last_now = (idx_r == 2'(cnt - 2'd1));
  assign take     = !sv_r || (out_tready && last_now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= 1'b0;
      idx_r <= '0;
    end else if (take) begin
      sv_r  <= rec_valid;
      idx_r <= '0;
    end else if (out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) rec_r <= rec;
  end

  always_comb begin
    kind = KIND_REJ;
    px = '0; py = '0; pz = '0; tx = '0; tz = '0;
    tu = '0; tv = '0;
    ca = '0; cb = '0; cc = '0;
    case (rec_r.m.cls)
      CLS_POLE: begin
        kind = KIND_VTX;
        if (idx_r == 2'd0) begin
          py = 16'sh7fff;
          tv = 17'd65536;
        end else begin
          py = 16'sh8000;
        end
      end
      CLS_CAP: begin
        kind = KIND_TRI;
        if (idx_r == 2'd0) begin
          ca = rec_r.m.t0a; cb = rec_r.m.t0b; cc = rec_r.m.t0c;
        end else begin
          ca = rec_r.m.t1a; cb = rec_r.m.t1b; cc = rec_r.m.t1c;
        end
      end
      CLS_GRID: begin
        if (idx_r == 2'd0) begin
          kind = KIND_VTX;
          px = rec_r.px;
          py = rec_r.py;
          pz = rec_r.pz;
          tx = (rec_r.pz == 16'sh8000) ? 16'sh7fff : -rec_r.pz;
          tz = rec_r.px;
          tu = rec_r.m.tu;
          tv = rec_r.m.tv;
        end else if (idx_r == 2'd1) begin
          kind = KIND_TRI;
          ca = rec_r.m.t0a; cb = rec_r.m.t0b; cc = rec_r.m.t0c;
        end else begin
          kind = KIND_TRI;
          ca = rec_r.m.t1a; cb = rec_r.m.t1b; cc = rec_r.m.t1c;
        end
      end
      default: kind = KIND_REJ;
    endcase
  end

  assign out_tvalid = sv_r;
  assign out_tuser  = kind;
  assign out_tlast  = last_now;
  assign out_tdata  = {2'b0, cc, cb, ca, tv, tu, tz, tx, pz, py, px};

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> (idx_r < cnt))
    else $error("result index beyond count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && !out_tready) |=> (sv_r && $stable(idx_r) && $stable(rec_r)))
    else $error("record changed while stalled");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && out_tready && !last_now) |=> (sv_r && idx_r == 2'($past(idx_r) + 2'd1)))
    else $error("result index did not advance");

endmodule
`default_nettype wire

FILE: verif/uv_sphere_tessellator_test.sv
`default_nettype none
module uv_sphere_tessellator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import uvs_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] px, py, pz, tx, tz;
    logic [16:0]        tu, tv;
    logic [19:0]        ca, cb, cc;
    logic               last;
  } mesh_rec_t;

  class mesh_scoreboard;
    mesh_rec_t pending[$];
    longint    slices = 16;
    longint    stacks = 8;
    int        errors = 0;

    function void write_reg(logic [0:0] idx, longint val);
      if (idx == REG_SLICES) slices = (val < 3) ? 3 : (val > MAX_SLICES) ? MAX_SLICES : val;
      else stacks = (val < 2) ? 2 : (val > MAX_STACKS) ? MAX_STACKS : val;
    endfunction

    // cos and sin of a turn phase, q2.30
    function void sincos(logic [31:0] phase, output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = phase[29:0];
      for (int k = 0; k < 18; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_turn(k);
        end else begin
          x += dx; y -= dy; z += atan_turn(k);
        end
      end
      case (phase[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint clip16(longint v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function void push_vtx(longint px, longint py, longint pz, longint tu, longint tv,
                           logic last);
      mesh_rec_t r;
      r = '0;
      r.kind = KIND_VTX;
      r.px = 16'(px); r.py = 16'(py); r.pz = 16'(pz);
      r.tx = 16'(clip16(-pz)); r.tz = 16'(px);
      r.tu = 17'(tu); r.tv = 17'(tv);
      r.last = last;
      pending.push_back(r);
    endfunction

    function void push_tri(longint a, longint b, longint c, logic last);
      mesh_rec_t r;
      r = '0;
      r.kind = KIND_TRI;
      r.ca = a[19:0]; r.cb = b[19:0]; r.cc = c[19:0];
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_input(logic [1:0] op, logic [9:0] si, logic [9:0] rj);
      longint i, j, nj, prev, ca, sa, cb, sb;
      logic [63:0] pa, pb;
      mesh_rec_t r;
      i = si; j = rj; nj = stacks - 1;
      if (op == OP_POLE) begin
        push_vtx(0, 32767, 0, 0, 65536, 0);
        push_vtx(0, -32768, 0, 0, 0, 1);
        return;
      end
      if (op > OP_CAP || i >= slices || (op == OP_GRID && (j == 0 || j >= stacks))) begin
        r = '0;
        r.kind = KIND_REJ;
        r.last = 1;
        pending.push_back(r);
        return;
      end
      prev = (i == 0) ? slices - 1 : i - 1;
      if (op == OP_CAP) begin
        push_tri(slices * nj, prev * nj, i * nj, 0);
        push_tri(i * nj + nj - 1, prev * nj + nj - 1, slices * nj + 1, 1);
        return;
      end
      pa = (64'(i) << 32) / 64'(slices);
      pb = (64'(j) << 31) / 64'(stacks);
      sincos(pa[31:0], ca, sa);
      sincos(pb[31:0], cb, sb);
      push_vtx(clip16((sb * sa + (64'sd1 << 44)) >>> 45),
               clip16((cb + 16384) >>> 15),
               clip16((sb * ca + (64'sd1 << 44)) >>> 45),
               (i * 131072 + slices) / (2 * slices),
               65536 - (j * 131072 + stacks) / (2 * stacks), j == 1);
      if (j == 1) return;
      push_tri(prev * nj + j - 2, prev * nj + j - 1, i * nj + j - 2, 0);
      push_tri(prev * nj + j - 1, i * nj + j - 1, i * nj + j - 2, 1);
    endfunction

    function void field_chk(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(mesh_rec_t act);
      mesh_rec_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_chk("kind", e.kind, act.kind);
      field_chk("pos_x", e.px, act.px);
      field_chk("pos_y", e.py, act.py);
      field_chk("pos_z", e.pz, act.pz);
      field_chk("tangent_x", e.tx, act.tx);
      field_chk("tangent_z", e.tz, act.tz);
      field_chk("tex_u", e.tu, act.tu);
      field_chk("tex_v", e.tv, act.tv);
      field_chk("corner_a", e.ca, act.ca);
      field_chk("corner_b", e.cb, act.cb);
      field_chk("corner_c", e.cc, act.cc);
      field_chk("last", e.last, act.last);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [175:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en = 0;
  logic [0:0]   cfg_index = '0;
  logic [10:0]  cfg_data = '0;

  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  longint         cycles = 0;
  mesh_scoreboard sb = new();

  uv_sphere_tessellator dut (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[9:0], in_tdata[19:10]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32],
                       out_tdata[63:48], out_tdata[79:64], out_tdata[96:80],
                       out_tdata[113:97], out_tdata[133:114], out_tdata[153:134],
                       out_tdata[173:154], out_tlast});
  end

  // one transaction on the input side, entered and left at a falling edge
  task send_item(logic [1:0] op, logic [9:0] si, logic [9:0] rj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, rj, si};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task drain_and_write(logic [10:0] slices_val, logic [10:0] stacks_val);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 5) @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= REG_SLICES;
    cfg_data <= slices_val;
    @(negedge clk);
    cfg_index <= REG_STACKS;
    cfg_data <= stacks_val;
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.write_reg(REG_SLICES, slices_val);
    sb.write_reg(REG_STACKS, stacks_val);
  endtask

  task random_items(int n);
    logic [1:0] op;
    logic [9:0] si, rj;
    int         pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      op = (pick < 70) ? OP_GRID : (pick < 80) ? OP_POLE : (pick < 95) ? OP_CAP : OP_UNUSED;
      si = 10'($urandom_range(sb.slices - 1));
      rj = 10'($urandom_range(sb.stacks - 1, 1));
      // some noise outside the legal index range
      if ($urandom_range(9) == 0) si = 10'($urandom);
      if ($urandom_range(9) == 0) rj = 10'($urandom);
      send_item(op, si, rj);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed, reset setting of 16 slices and 8 stacks
    send_item(OP_GRID, 0, 1);
    send_item(OP_GRID, 0, 7);
    send_item(OP_GRID, 15, 7);
    send_item(OP_GRID, 15, 1);
    send_item(OP_GRID, 1, 4);
    send_item(OP_GRID, 8, 4);
    send_item(OP_GRID, 4, 2);
    send_item(OP_GRID, 12, 6);
    send_item(OP_GRID, 0, 0);
    send_item(OP_GRID, 0, 8);
    send_item(OP_GRID, 16, 3);
    send_item(OP_GRID, 10'h3ff, 10'h3ff);
    send_item(OP_POLE, 10'h3ff, 10'h3ff);
    send_item(OP_POLE, 0, 0);
    send_item(OP_CAP, 0, 0);
    send_item(OP_CAP, 15, 10'h3ff);
    send_item(OP_CAP, 16, 0);
    send_item(OP_UNUSED, 10'h3ff, 10'h3ff);
    send_item(OP_UNUSED, 0, 0);
    random_items(30);

    drain_and_write(0, 0);
    send_idle_pct = 77;
    random_items(35);

    drain_and_write(11'h7ff, 1024);
    send_idle_pct = 0;
    recv_stall_pct = 77;
    random_items(40);

    drain_and_write(37, 13);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    random_items(45);

    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LAT + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
